/* hw/rtl/klock_pkg.sv */
// ----------------------------------------------------------------------------
// klock_pkg
// Shared types, key codes, event codes and state layout for the keypad lock.
// ----------------------------------------------------------------------------
`default_nettype none

package klock_pkg;

  localparam int CODE_LEN = 4;
  localparam int POS_W    = $clog2(CODE_LEN + 1);

  localparam logic [7:0] KEY_ERASE   = 8'd98;
  localparam logic [7:0] KEY_SET     = 8'd112;
  localparam logic [7:0] KEY_UNLOCK  = 8'd117;
  localparam logic [7:0] KEY_LOCK    = 8'd108;
  localparam logic [7:0] KEY_DEFAULT = 8'd109;

  localparam logic [2:0] FAIL_SAT         = 3'd7;
  localparam logic [2:0] MAX_FAIL_RESET   = 3'd3;
  localparam logic [7:0] LOCK_TICKS_RESET = 8'd10;

  localparam logic CFG_MAX_FAIL   = 1'b0;
  localparam logic CFG_LOCK_TICKS = 1'b1;

  typedef enum logic [1:0] {
    MODE_ENTRY   = 2'd0,
    MODE_MENU    = 2'd1,
    MODE_SET     = 2'd2,
    MODE_LOCKOUT = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    EV_IGNORED     = 4'd0,
    EV_STORED      = 4'd1,
    EV_ERASED      = 4'd2,
    EV_ACCEPTED    = 4'd3,
    EV_REJECTED    = 4'd4,
    EV_LOCKOUT     = 4'd5,
    EV_UNLOCKED    = 4'd6,
    EV_ALREADY_OPEN = 4'd7,
    EV_LOCKED      = 4'd8,
    EV_ALREADY_LOCKED = 4'd9,
    EV_CODE_SET    = 4'd10,
    EV_TICK        = 4'd11,
    EV_LOCKOUT_OVER = 4'd12
  } event_t;

  typedef logic [CODE_LEN-1:0][7:0] code_t;

  typedef struct packed {
    mode_t            mode;
    logic             door;
    logic [POS_W-1:0] pos;
    logic [2:0]       fails;
    logic [7:0]       left;
  } lock_st_t;

endpackage

`default_nettype wire

/* hw/rtl/klock_step.sv */
// ----------------------------------------------------------------------------
// klock_step
// Next-state and event logic for one key or tick word.
// ----------------------------------------------------------------------------
`default_nettype none

module klock_step (
  input  wire logic                 is_tick,
  input  wire logic [7:0]           key,
  input  wire klock_pkg::lock_st_t  st,
  input  wire klock_pkg::code_t     entry_buf,
  input  wire klock_pkg::code_t     stored_code,
  input  wire logic [2:0]           max_fail,
  input  wire logic [7:0]           lock_ticks,
  output klock_pkg::lock_st_t       st_nxt,
  output klock_pkg::code_t          buf_nxt,
  output logic                      code_we,
  output klock_pkg::event_t         ev
);
  import klock_pkg::*;

  logic             is_erase;
  logic [POS_W-1:0] pos_inc;
  logic             full;
  logic [2:0]       fails_inc;

  assign is_erase  = (key == KEY_ERASE);
  assign pos_inc   = st.pos + POS_W'(1);
  assign full      = (pos_inc == POS_W'(CODE_LEN));
  assign fails_inc = (st.fails != FAIL_SAT) ? st.fails + 3'd1 : st.fails;

  always_comb begin
    buf_nxt = entry_buf;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (st.pos == POS_W'(i)) begin
        buf_nxt[i] = key;
      end
    end
  end

  always_comb begin
    st_nxt  = st;
    code_we = 1'b0;
    ev      = EV_IGNORED;
    if (is_tick) begin
      if (st.mode == MODE_LOCKOUT) begin
        if (st.left > 8'd1) begin
          st_nxt.left = st.left - 8'd1;
          ev          = EV_TICK;
        end else begin
          st_nxt.left = 8'd0;
          st_nxt.mode = MODE_ENTRY;
          ev          = EV_LOCKOUT_OVER;
        end
      end
    end else begin
      case (st.mode)
        MODE_ENTRY, MODE_SET: begin
          if (is_erase) begin
            if (st.pos != '0) begin
              st_nxt.pos = st.pos - POS_W'(1);
              ev         = EV_ERASED;
            end
          end else if (!full) begin
            st_nxt.pos = pos_inc;
            ev         = EV_STORED;
          end else begin
            st_nxt.pos = '0;
            if (st.mode == MODE_SET) begin
              code_we     = 1'b1;
              st_nxt.mode = MODE_ENTRY;
              ev          = EV_CODE_SET;
            end else if (buf_nxt == stored_code) begin
              st_nxt.fails = 3'd0;
              st_nxt.door  = 1'b0;
              st_nxt.mode  = MODE_MENU;
              ev           = EV_ACCEPTED;
            end else if (fails_inc >= max_fail) begin
              st_nxt.fails = 3'd0;
              st_nxt.left  = lock_ticks;
              st_nxt.mode  = MODE_LOCKOUT;
              ev           = EV_LOCKOUT;
            end else begin
              st_nxt.fails = fails_inc;
              ev           = EV_REJECTED;
            end
          end
        end
        MODE_MENU: begin
          if (key == KEY_SET) begin
            st_nxt.pos  = '0;
            st_nxt.mode = MODE_SET;
            ev          = EV_ACCEPTED;
          end else if (key == KEY_UNLOCK) begin
            st_nxt.door = 1'b1;
            ev          = st.door ? EV_ALREADY_OPEN : EV_UNLOCKED;
          end else if (key == KEY_LOCK) begin
            st_nxt.door = 1'b0;
            ev          = st.door ? EV_LOCKED : EV_ALREADY_LOCKED;
          end
        end
        default: begin
          ev = EV_IGNORED;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/keypad_code_lock_top.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock_top
// Keypad code lock: key entry, code check, menu, code change and lockout.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// in_       in   tdata[7:0] key_code, tuser[0] opcode (0 key, 1 tick)
// out_      out  tdata: event_res, mode, door_open, entry_count,
//                failure_count, lockout_left
// cfg_      in   addr 0 max_failures, 1 lockout_ticks
//
// One word per cycle while the result side is not stalled; an accepted word is
// registered in the input register, and its result then in the result register.
// The lock state updates in the single step between input and result register.
// rst_n is synchronous; it clears state, sets the stored code to 'm' and sets the
// config to its reset values. A stalled result holds the input register; the input
// side refills while the result register drains.
`default_nettype none

module keypad_code_lock_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] key_code
  input  wire logic        in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] event_res, [5:4] mode, [6] door_open,
                                       // [9:7] entry_count, [12:10] failure_count,
                                       // [20:13] lockout_left, [23:21] zero
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);
  import klock_pkg::*;

  logic       in_valid_r;
  logic       in_tick_r;
  logic [7:0] in_key_r;
  logic       out_free;
  logic       advance;

  lock_st_t   st_r;
  lock_st_t   st_nxt;
  code_t      buf_r;
  code_t      buf_nxt;
  code_t      code_r;
  logic       code_we;
  event_t     ev;
  logic [2:0] max_fail_r;
  logic [7:0] lock_ticks_r;

  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic [23:0] out_data_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_tick_r <= in_tuser;
      in_key_r  <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fail_r   <= MAX_FAIL_RESET;
      lock_ticks_r <= LOCK_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_FAIL:   max_fail_r   <= cfg_wdata[2:0];
        CFG_LOCK_TICKS: lock_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  klock_step u_step (
    .is_tick     (in_tick_r),
    .key         (in_key_r),
    .st          (st_r),
    .entry_buf   (buf_r),
    .stored_code (code_r),
    .max_fail    (max_fail_r),
    .lock_ticks  (lock_ticks_r),
    .st_nxt      (st_nxt),
    .buf_nxt     (buf_nxt),
    .code_we     (code_we),
    .ev          (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: MODE_ENTRY, door: 1'b0, pos: '0, fails: 3'd0, left: 8'd0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      buf_r <= buf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= code_t'({CODE_LEN{KEY_DEFAULT}});
    end else if (advance && code_we) begin
      code_r <= buf_nxt;
    end
  end

  assign out_data_nxt = {3'b000, st_nxt.left, st_nxt.fails, 3'(st_nxt.pos),
                         st_nxt.door, st_nxt.mode, ev};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_left_only_in_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode != MODE_LOCKOUT |-> st_r.left == 8'd0)
    else $error("lockout count nonzero outside lockout");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pos < POS_W'(CODE_LEN))
    else $error("entry position past code length");

  a_pos_empty_menu_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_MENU || st_r.mode == MODE_LOCKOUT) |-> st_r.pos == '0)
    else $error("entry buffer not empty in menu or lockout");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("processed word produced no result");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(in_key_r) && $stable(in_tick_r))
    else $error("input word lost during output stall");

endmodule

`default_nettype wire

/* verif/klock_tb_pkg.sv */
// ----------------------------------------------------------------------------
// klock_tb_pkg
// Lock-state tracker for the keypad code lock bench. It mirrors the lock state
// and register settings, predicts the result word of every accepted key or
// tick word, and checks result words in order against those predictions.
// ----------------------------------------------------------------------------
package klock_tb_pkg;

  import klock_pkg::*;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] left;
    logic [2:0] fails;
    logic [2:0] count;
    logic       door;
    mode_t      mode;
    event_t     ev;
  } lock_word_t;

  class klock_tracker;

    mode_t      mode;
    code_t      keys;
    code_t      code;
    int         pos;
    logic [2:0] fails;
    logic       door;
    logic [7:0] left;
    logic [2:0] max_fail;
    logic [7:0] lock_ticks;

    int         errors;
    lock_word_t awaited_words[$];

    function new();
      mode       = MODE_ENTRY;
      keys       = '0;
      code       = {CODE_LEN{KEY_DEFAULT}};
      pos        = 0;
      fails      = '0;
      door       = 1'b0;
      left       = '0;
      max_fail   = MAX_FAIL_RESET;
      lock_ticks = LOCK_TICKS_RESET;
      errors     = 0;
    endfunction

    task flag_mismatch(input string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    function void write_cfg(input logic addr, input logic [7:0] data);
      if (addr == CFG_MAX_FAIL) max_fail = data[2:0];
      else lock_ticks = data;
    endfunction

    function int pending();
      return awaited_words.size();
    endfunction

    // erase or store one key
    function event_t take_key(input logic [7:0] key);
      if (key == KEY_ERASE) begin
        if (pos == 0) return EV_IGNORED;
        pos--;
        return EV_ERASED;
      end
      if (pos < CODE_LEN) begin
        keys[pos] = key;
        pos++;
      end
      return EV_STORED;
    endfunction

    function event_t entry_key(input logic [7:0] key);
      event_t ev;
      ev = take_key(key);
      if (ev != EV_STORED || pos < CODE_LEN) return ev;
      pos = 0;
      if (keys == code) begin
        fails = '0;
        door  = 1'b0;
        mode  = MODE_MENU;
        return EV_ACCEPTED;
      end
      if (fails < FAIL_SAT) fails++;
      if (fails >= max_fail) begin
        fails = '0;
        left  = lock_ticks;
        mode  = MODE_LOCKOUT;
        return EV_LOCKOUT;
      end
      return EV_REJECTED;
    endfunction

    function event_t menu_key(input logic [7:0] key);
      if (key == KEY_SET) begin
        pos  = 0;
        mode = MODE_SET;
        return EV_ACCEPTED;
      end
      if (key == KEY_UNLOCK) begin
        if (door) return EV_ALREADY_OPEN;
        door = 1'b1;
        return EV_UNLOCKED;
      end
      if (key == KEY_LOCK) begin
        if (!door) return EV_ALREADY_LOCKED;
        door = 1'b0;
        return EV_LOCKED;
      end
      return EV_IGNORED;
    endfunction

    function event_t set_key(input logic [7:0] key);
      event_t ev;
      ev = take_key(key);
      if (ev != EV_STORED || pos < CODE_LEN) return ev;
      code = keys;
      pos  = 0;
      mode = MODE_ENTRY;
      return EV_CODE_SET;
    endfunction

    // advance the lock by one accepted word and queue the result it causes
    function event_t note_word(input logic op, input logic [7:0] key);
      event_t     ev;
      lock_word_t w;
      ev = EV_IGNORED;
      if (op == OP_TICK) begin
        if (mode == MODE_LOCKOUT) begin
          if (left > 8'd1) begin
            left--;
            ev = EV_TICK;
          end else begin
            left = '0;
            mode = MODE_ENTRY;
            ev   = EV_LOCKOUT_OVER;
          end
        end
      end else begin
        case (mode)
          MODE_ENTRY: ev = entry_key(key);
          MODE_MENU:  ev = menu_key(key);
          MODE_SET:   ev = set_key(key);
          default:    ev = EV_IGNORED;
        endcase
      end
      w.pad   = '0;
      w.ev    = ev;
      w.mode  = mode;
      w.door  = door;
      w.count = 3'(pos);
      w.fails = fails;
      w.left  = left;
      awaited_words.push_back(w);
      return ev;
    endfunction

    task check_word(input logic [23:0] tdata);
      lock_word_t got;
      lock_word_t exp;
      got = lock_word_t'(tdata);
      if (awaited_words.size() == 0) begin
        flag_mismatch($sformatf("result word %h with none expected", tdata));
        return;
      end
      exp = awaited_words.pop_front();
      if (got.ev !== exp.ev)
        flag_mismatch($sformatf("event_res got %0d exp %0d", got.ev, exp.ev));
      if (got.mode !== exp.mode)
        flag_mismatch($sformatf("mode got %0d exp %0d", got.mode, exp.mode));
      if (got.door !== exp.door)
        flag_mismatch($sformatf("door_open got %0d exp %0d", got.door, exp.door));
      if (got.count !== exp.count)
        flag_mismatch($sformatf("entry_count got %0d exp %0d", got.count, exp.count));
      if (got.fails !== exp.fails)
        flag_mismatch($sformatf("failure_count got %0d exp %0d", got.fails, exp.fails));
      if (got.left !== exp.left)
        flag_mismatch($sformatf("lockout_left got %0d exp %0d", got.left, exp.left));
    endtask

  endclass

endpackage

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Bench for keypad_code_lock_top. A short directed sequence covers erase,
// wrong and right codes, menu keys and entry into code change; then random key and tick
// words, mostly shaped as code attempts, run under several register settings
// with random gaps and stalls. Every result word is checked against the
// lock-state tracker.
// ----------------------------------------------------------------------------
module tb;

  import klock_pkg::*;
  import klock_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int NUM_PHASES     = 6;

  localparam logic [8:0] OPENING [26] = '{
    {OP_TICK, 8'h00}, {OP_KEY, KEY_ERASE}, {OP_KEY, 8'h00}, {OP_KEY, KEY_ERASE},
    {OP_KEY, 8'hFF}, {OP_KEY, 8'h80}, {OP_KEY, 8'h7F}, {OP_KEY, 8'h01},
    {OP_KEY, KEY_DEFAULT}, {OP_KEY, KEY_DEFAULT}, {OP_KEY, KEY_DEFAULT},
    {OP_KEY, KEY_DEFAULT}, {OP_KEY, 8'h00}, {OP_KEY, KEY_LOCK},
    {OP_KEY, KEY_UNLOCK}, {OP_KEY, KEY_UNLOCK}, {OP_KEY, KEY_LOCK},
    {OP_KEY, KEY_UNLOCK}, {OP_TICK, 8'hFF}, {OP_KEY, KEY_SET},
    {OP_KEY, KEY_ERASE}, {OP_KEY, 8'h61}, {OP_KEY, KEY_ERASE},
    {OP_KEY, 8'h31}, {OP_KEY, 8'h32}, {OP_KEY, 8'h33}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic        cfg_addr;
  logic [7:0]  cfg_wdata;

  klock_tracker sb = new();

  bit idle_en   = 1'b1;
  bit aim_match = 1'b0;
  int idle_cycles = 0;

  keypad_code_lock_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_word(out_tdata);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || cfg_we || (in_tvalid && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] key);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    do @(posedge clk); while (in_tready !== 1'b1);
    void'(sb.note_word(op, key));
  endtask

  // hold input low until every expected result word is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_cfg(addr, data);
  endtask

  task automatic pick_word(output logic op, output logic [7:0] key);
    int roll;
    roll = $urandom_range(0, 99);
    op   = OP_KEY;
    key  = 8'($urandom_range(0, 255));
    if (roll < 5) begin
      op = 1'($urandom_range(0, 1));
      return;
    end
    case (sb.mode)
      MODE_ENTRY: begin
        if (sb.pos == 0) aim_match = 1'($urandom_range(0, 1));
        if (roll < 12) key = KEY_ERASE;
        else if (aim_match && roll < 94) key = sb.code[sb.pos];
      end
      MODE_MENU: begin
        if (roll < 35) key = KEY_UNLOCK;
        else if (roll < 65) key = KEY_LOCK;
        else if (roll < 85) key = KEY_SET;
      end
      MODE_SET: begin
        if (roll < 15) key = KEY_ERASE;
      end
      default: begin
        if (roll < 90) op = OP_TICK;
      end
    endcase
  endtask

  task automatic run_random(input int target, input bit calm);
    int   sent;
    logic op;
    logic [7:0] key;
    sent = 0;
    idle_en = !calm;
    while (sent < target) begin
      if (sent % 60 == 0) idle_en = !calm && ($urandom_range(0, 3) != 0);
      if (!calm && $urandom_range(0, 199) == 0) wait_drained();
      pick_word(op, key);
      send_word(op, key);
      sent++;
    end
  endtask

  initial begin
    int unsigned fail_set [NUM_PHASES];
    int unsigned tick_set [NUM_PHASES];
    int          word_set [NUM_PHASES];
    fail_set = '{3, 7, 1, 0, 2, 5};
    tick_set = '{10, 1, 255, 0, 3, 2};
    word_set = '{250, 200, 150, 150, 150, 150};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_MAX_FAIL;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_word(OPENING[i][8], OPENING[i][7:0]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_reg(CFG_MAX_FAIL, 8'(fail_set[p]));
        write_reg(CFG_LOCK_TICKS, 8'(tick_set[p]));
      end
      run_random(word_set[p], p == NUM_PHASES - 1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d result words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/klock_pkg.sv
hw/rtl/klock_step.sv
hw/rtl/keypad_code_lock_top.sv
verif/klock_tb_pkg.sv
verif/tb.sv
